[design/line_follower_pid_drive_top_defines.svh]
// assertion macros for the line follower pid drive block
// used by line_follower_pid_drive_top; expects clock and reset in scope
`ifndef LINE_FOLLOWER_PID_DRIVE_TOP_DEFINES_SVH
`define LINE_FOLLOWER_PID_DRIVE_TOP_DEFINES_SVH

// condition holds in the same cycle
`define LFPD_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lfpd: same cycle check failed");

// condition holds in the following cycle
`define LFPD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lfpd: next cycle check failed");

`endif

[design/lfpd_pkg.sv]
// shared types and constants of the line follower pid drive block
// no dependencies; used by every module of the block
`default_nettype none

package lfpd_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int FRAC_BITS    = 8;

   localparam int REQ_DATA_W = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
   localparam int WSUM_W     = SAMPLE_BITS + $clog2(SENSOR_COUNT * SENSOR_COUNT / 4 + 1) + 1;
   localparam int MAG_W      = WSUM_W - 1;
   localparam int NUM_W      = MAG_W + FRAC_BITS;
   localparam int TOTAL_W    = SAMPLE_BITS + $clog2(SENSOR_COUNT);
   localparam int DIV_CNT_W  = $clog2(NUM_W);

   localparam int POS_W       = 11;
   localparam int POS_MAX_MAG = 2 ** (POS_W - 1) - 1;
   localparam int POS_NEG_MAG = 2 ** (POS_W - 1);
   localparam int INTEG_W     = 24;
   localparam int GAIN_W      = 12;
   localparam int SPEED_W     = 13;
   localparam int LIMIT_W     = 12;
   localparam int TOTAL_OUT_W = 13;

   localparam int PROD_W     = GAIN_W + 1 + INTEG_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int CORR_W     = ACC_W - FRAC_BITS;
   localparam int ROUND_BIAS = 2 ** FRAC_BITS - 1;

   localparam int RSP_DATA_W = ((2 * SPEED_W + POS_W + TOTAL_OUT_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT      = 3'd4;

   localparam logic [GAIN_W-1:0]         RESET_GAIN_P = 12'd768;
   localparam logic [GAIN_W-1:0]         RESET_GAIN_I = 12'd0;
   localparam logic [GAIN_W-1:0]         RESET_GAIN_D = 12'd717;
   localparam logic signed [SPEED_W-1:0] RESET_BASE   = 13'sd3840;
   localparam logic [LIMIT_W-1:0]        RESET_LIMIT  = 12'd3840;

   typedef struct packed {
      logic [GAIN_W-1:0]         gain_proportional;
      logic [GAIN_W-1:0]         gain_integral;
      logic [GAIN_W-1:0]         gain_derivative;
      logic signed [SPEED_W-1:0] base_speed;
      logic [LIMIT_W-1:0]        speed_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV,
      OP_POS,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_ACCUM,
      OP_ROUND,
      OP_DRIVE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_POSITION,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACCUM,
      ST_ROUND,
      ST_DRIVE
   } ctrl_state_type;

endpackage

`default_nettype wire

[design/lfpd_csr.sv]
// configuration registers: gains, base speed and speed limit
// depends on lfpd_pkg
`default_nettype none

module lfpd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lfpd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lfpd_pkg::CSR_DATA_W-1:0]    csr_data,
   output lfpd_pkg::cfg_type                       cfg
);

   lfpd_pkg::cfg_type cfg_ff;
   lfpd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lfpd_pkg::REG_GAIN_P: begin
               cfg_in.gain_proportional = csr_data[lfpd_pkg::GAIN_W-1:0];
            end
            lfpd_pkg::REG_GAIN_I: begin
               cfg_in.gain_integral = csr_data[lfpd_pkg::GAIN_W-1:0];
            end
            lfpd_pkg::REG_GAIN_D: begin
               cfg_in.gain_derivative = csr_data[lfpd_pkg::GAIN_W-1:0];
            end
            lfpd_pkg::REG_BASE_SPEED: begin
               cfg_in.base_speed = signed'(csr_data[lfpd_pkg::SPEED_W-1:0]);
            end
            lfpd_pkg::REG_LIMIT: begin
               cfg_in.speed_limit = csr_data[lfpd_pkg::LIMIT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_proportional <= lfpd_pkg::RESET_GAIN_P;
         cfg_ff.gain_integral     <= lfpd_pkg::RESET_GAIN_I;
         cfg_ff.gain_derivative   <= lfpd_pkg::RESET_GAIN_D;
         cfg_ff.base_speed        <= lfpd_pkg::RESET_BASE;
         cfg_ff.speed_limit       <= lfpd_pkg::RESET_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[design/lfpd_ctrl.sv]
// sequencer of the drive step: divide, pid multiplies, result hand-off
// depends on lfpd_pkg; drives lfpd_datapath through dp_cmd_type
`default_nettype none

module lfpd_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output lfpd_pkg::dp_cmd_type cmd
);

   lfpd_pkg::ctrl_state_type state_ff;
   lfpd_pkg::ctrl_state_type state_in;
   logic [lfpd_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [lfpd_pkg::DIV_CNT_W-1:0] div_cnt_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic drive_ok;

   assign drive_ok   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         lfpd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in   = lfpd_pkg::ST_DIVIDE;
               div_cnt_in = lfpd_pkg::DIV_CNT_W'(lfpd_pkg::NUM_W - 1);
            end
         end
         lfpd_pkg::ST_DIVIDE: begin
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = lfpd_pkg::ST_POSITION;
            end
         end
         lfpd_pkg::ST_POSITION: state_in = lfpd_pkg::ST_MUL_P;
         lfpd_pkg::ST_MUL_P:    state_in = lfpd_pkg::ST_MUL_I;
         lfpd_pkg::ST_MUL_I:    state_in = lfpd_pkg::ST_MUL_D;
         lfpd_pkg::ST_MUL_D:    state_in = lfpd_pkg::ST_ACCUM;
         lfpd_pkg::ST_ACCUM:    state_in = lfpd_pkg::ST_ROUND;
         lfpd_pkg::ST_ROUND:    state_in = lfpd_pkg::ST_DRIVE;
         lfpd_pkg::ST_DRIVE: begin
            if (drive_ok) begin
               state_in = lfpd_pkg::ST_IDLE;
            end
         end
         default: state_in = lfpd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      cmd.op       = lfpd_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         lfpd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = lfpd_pkg::OP_LOAD;
            end
         end
         lfpd_pkg::ST_DIVIDE:   cmd.op = lfpd_pkg::OP_DIV;
         lfpd_pkg::ST_POSITION: cmd.op = lfpd_pkg::OP_POS;
         lfpd_pkg::ST_MUL_P:    cmd.op = lfpd_pkg::OP_MUL_P;
         lfpd_pkg::ST_MUL_I:    cmd.op = lfpd_pkg::OP_MUL_I;
         lfpd_pkg::ST_MUL_D:    cmd.op = lfpd_pkg::OP_MUL_D;
         lfpd_pkg::ST_ACCUM:    cmd.op = lfpd_pkg::OP_ACCUM;
         lfpd_pkg::ST_ROUND:    cmd.op = lfpd_pkg::OP_ROUND;
         lfpd_pkg::ST_DRIVE: begin
            if (drive_ok) begin
               cmd.op       = lfpd_pkg::OP_DRIVE;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.op = lfpd_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfpd_pkg::ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/lfpd_datapath.sv]
// datapath: centroid sums, restoring divider, shared pid multiplier, clamps
// depends on lfpd_pkg; sequenced by lfpd_ctrl
`default_nettype none

module lfpd_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire lfpd_pkg::dp_cmd_type                   cmd,
   input  wire lfpd_pkg::cfg_type                      cfg,
   input  wire logic [lfpd_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic signed [lfpd_pkg::SPEED_W-1:0]         wheel_left,
   output logic signed [lfpd_pkg::SPEED_W-1:0]         wheel_right,
   output logic signed [lfpd_pkg::POS_W-1:0]           line_position,
   output logic [lfpd_pkg::TOTAL_OUT_W-1:0]            sample_total
);

   localparam int SC  = lfpd_pkg::SENSOR_COUNT;
   localparam int SB  = lfpd_pkg::SAMPLE_BITS;
   localparam int WW  = lfpd_pkg::WSUM_W;
   localparam int TW  = lfpd_pkg::TOTAL_W;
   localparam int NW  = lfpd_pkg::NUM_W;
   localparam int PW  = lfpd_pkg::POS_W;
   localparam int IW  = lfpd_pkg::INTEG_W;
   localparam int AW  = lfpd_pkg::ACC_W;
   localparam int CW  = lfpd_pkg::CORR_W;
   localparam int SW  = lfpd_pkg::SPEED_W;

   // division operands and result
   logic              neg_ff;
   logic [TW-1:0]     total_ff;
   logic [TW-1:0]     rem_ff;
   logic [NW-1:0]     quo_ff;
   logic signed [PW-1:0] pos_ff;
   // pid state
   logic signed [IW-1:0] integ_ff;
   logic signed [PW-1:0] prev_ff;
   logic signed [lfpd_pkg::PROD_W-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [CW-1:0] corr_ff;
   // result register
   logic signed [SW-1:0] left_ff;
   logic signed [SW-1:0] right_ff;
   logic signed [PW-1:0] pos_out_ff;
   logic [lfpd_pkg::TOTAL_OUT_W-1:0] total_out_ff;

   logic signed [WW-1:0] wsum;
   logic [TW-1:0]        tsum;
   logic [lfpd_pkg::MAG_W-1:0] wmag;

   logic [TW:0]          trial;
   logic                 trial_ge;
   logic [TW-1:0]        rem_in;
   logic [NW-1:0]        quo_in;
   logic signed [PW-1:0] pos_in;

   logic signed [IW:0]   isum;
   logic signed [IW-1:0] integ_in;
   logic signed [PW:0]   deriv;
   logic [lfpd_pkg::GAIN_W-1:0] gain_sel;
   logic signed [lfpd_pkg::GAIN_W:0] gain_ext;
   logic signed [IW-1:0] opnd_sel;
   logic signed [lfpd_pkg::PROD_W-1:0] mul_prod;

   logic signed [AW-1:0] acc_adj;
   logic signed [CW:0]   base_ext;
   logic signed [CW:0]   corr_ext;
   logic signed [CW:0]   lim_pos;
   logic signed [CW:0]   lim_neg;
   logic signed [CW:0]   left_raw;
   logic signed [CW:0]   right_raw;
   logic signed [CW:0]   left_clip;
   logic signed [CW:0]   right_clip;

   // weighted and plain sums of the samples
   always_comb begin
      logic signed [WW-1:0] weight;
      logic signed [WW-1:0] sample;
      wsum = '0;
      tsum = '0;
      for (int i = 0; i < SC; i++) begin
         weight = WW'(i) - WW'(SC / 2);
         sample = signed'(WW'(req_tdata[i*SB +: SB]));
         wsum   = wsum + weight * sample;
         tsum   = tsum + TW'(req_tdata[i*SB +: SB]);
      end
      wmag = wsum[WW-1] ? lfpd_pkg::MAG_W'(-wsum) : lfpd_pkg::MAG_W'(wsum);
   end

   // one restoring divide step
   always_comb begin
      trial    = {rem_ff, quo_ff[NW-1]};
      trial_ge = trial >= {1'b0, total_ff};
      rem_in   = trial_ge ? TW'(trial - {1'b0, total_ff}) : trial[TW-1:0];
      quo_in   = {quo_ff[NW-2:0], trial_ge};
   end

   // signed, saturated position from the quotient
   always_comb begin
      if (total_ff == '0) begin
         pos_in = '0;
      end else if (!neg_ff) begin
         pos_in = (quo_ff > NW'(lfpd_pkg::POS_MAX_MAG)) ?
                  PW'(lfpd_pkg::POS_MAX_MAG) : signed'(quo_ff[PW-1:0]);
      end else begin
         pos_in = (quo_ff > NW'(lfpd_pkg::POS_NEG_MAG)) ?
                  -PW'(lfpd_pkg::POS_NEG_MAG) : -signed'(quo_ff[PW-1:0]);
      end
   end

   // integral with saturation, derivative term
   always_comb begin
      isum = (IW+1)'(integ_ff) + (IW+1)'(pos_ff);
      if (isum[IW] != isum[IW-1]) begin
         integ_in = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
         integ_in = isum[IW-1:0];
      end
      deriv = (PW+1)'(pos_ff) - (PW+1)'(prev_ff);
   end

   // shared multiplier
   always_comb begin
      case (cmd.op)
         lfpd_pkg::OP_MUL_I: begin
            gain_sel = cfg.gain_integral;
            opnd_sel = integ_ff;
         end
         lfpd_pkg::OP_MUL_D: begin
            gain_sel = cfg.gain_derivative;
            opnd_sel = IW'(deriv);
         end
         default: begin
            gain_sel = cfg.gain_proportional;
            opnd_sel = IW'(pos_ff);
         end
      endcase
      gain_ext = signed'({1'b0, gain_sel});
      mul_prod = gain_ext * opnd_sel;
   end

   // truncation toward zero and wheel clamps
   always_comb begin
      acc_adj    = acc_ff + (acc_ff[AW-1] ? AW'(lfpd_pkg::ROUND_BIAS) : AW'(0));
      base_ext   = (CW+1)'(cfg.base_speed);
      corr_ext   = (CW+1)'(corr_ff);
      lim_pos    = signed'((CW+1)'(cfg.speed_limit));
      lim_neg    = -lim_pos;
      left_raw   = base_ext - corr_ext;
      right_raw  = base_ext + corr_ext;
      left_clip  = (left_raw > lim_pos) ? lim_pos :
                   ((left_raw < lim_neg) ? lim_neg : left_raw);
      right_clip = (right_raw > lim_pos) ? lim_pos :
                   ((right_raw < lim_neg) ? lim_neg : right_raw);
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         lfpd_pkg::OP_LOAD: begin
            neg_ff   <= wsum[WW-1];
            total_ff <= tsum;
            rem_ff   <= '0;
            quo_ff   <= {wmag, {lfpd_pkg::FRAC_BITS{1'b0}}};
         end
         lfpd_pkg::OP_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end
         lfpd_pkg::OP_POS: begin
            pos_ff <= pos_in;
         end
         lfpd_pkg::OP_MUL_P: begin
            prod_ff <= mul_prod;
         end
         lfpd_pkg::OP_MUL_I: begin
            acc_ff  <= AW'(prod_ff);
            prod_ff <= mul_prod;
         end
         lfpd_pkg::OP_MUL_D: begin
            acc_ff  <= acc_ff + AW'(prod_ff);
            prod_ff <= mul_prod;
         end
         lfpd_pkg::OP_ACCUM: begin
            acc_ff <= acc_ff + AW'(prod_ff);
         end
         lfpd_pkg::OP_ROUND: begin
            corr_ff <= acc_adj[AW-1:lfpd_pkg::FRAC_BITS];
         end
         lfpd_pkg::OP_DRIVE: begin
            left_ff      <= left_clip[SW-1:0];
            right_ff     <= right_clip[SW-1:0];
            pos_out_ff   <= pos_ff;
            total_out_ff <= lfpd_pkg::TOTAL_OUT_W'(total_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (cmd.op == lfpd_pkg::OP_MUL_P) begin
            integ_ff <= integ_in;
         end
         if (cmd.op == lfpd_pkg::OP_MUL_D) begin
            prev_ff <= pos_ff;
         end
      end
   end

   assign wheel_left    = left_ff;
   assign wheel_right   = right_ff;
   assign line_position = pos_out_ff;
   assign sample_total  = total_out_ff;

endmodule

`default_nettype wire

[design/line_follower_pid_drive_top.sv]
// Line follower PID drive.
// req channel: one item holds eight 10 bit IR samples in req_tdata, sensor 0
// in the lowest bits. rsp channel: one item per request with the left and
// right wheel speeds, the Q.8 line position and the sample total.
// csr channel: register index and data, always ready; registers are to be
// written when idle, which the block does not enforce: 0 proportional gain,
// 1 integral gain, 2 derivative gain, 3 base speed, 4 speed limit.
// A new request is taken only after the previous one has gone through the 23
// step restoring divider and the three passes through the single shared
// multiplier and has left the last step.
// Reset (synchronous) clears the integral and last error, restores the
// register defaults and empties the result register.
// The result register holds its item while rsp_tready is low; the next
// request may be taken meanwhile, and its result waits in the last step until
// the register is free.
// depends on lfpd_pkg, lfpd_csr, lfpd_ctrl, lfpd_datapath and the defines header
`default_nettype none
`include "line_follower_pid_drive_top_defines.svh"

module line_follower_pid_drive_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // ir_sample_0 .. ir_sample_7, 10 bits each, zero pad to 80 bits
   input  wire logic [lfpd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // wheel_left 13, wheel_right 13, line_position 11, sample_total 13, zero pad
   output logic [lfpd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lfpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lfpd_pkg::CSR_DATA_W-1:0]   csr_data
);

   lfpd_pkg::cfg_type    cfg;
   lfpd_pkg::dp_cmd_type cmd;
   logic signed [lfpd_pkg::SPEED_W-1:0] wheel_left;
   logic signed [lfpd_pkg::SPEED_W-1:0] wheel_right;
   logic signed [lfpd_pkg::POS_W-1:0]   line_position;
   logic [lfpd_pkg::TOTAL_OUT_W-1:0]    sample_total;
   logic signed [lfpd_pkg::SPEED_W:0]   limit_pos;
   logic signed [lfpd_pkg::SPEED_W:0]   limit_neg;
   logic signed [lfpd_pkg::SPEED_W:0]   left_ext;
   logic signed [lfpd_pkg::SPEED_W:0]   right_ext;

   lfpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lfpd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_tdata     (req_tdata),
      .wheel_left    (wheel_left),
      .wheel_right   (wheel_right),
      .line_position (line_position),
      .sample_total  (sample_total)
   );

   assign rsp_tdata = lfpd_pkg::RSP_DATA_W'({sample_total, line_position,
                                             wheel_right, wheel_left});

   assign limit_pos = signed'((lfpd_pkg::SPEED_W+1)'(cfg.speed_limit));
   assign limit_neg = -limit_pos;
   assign left_ext  = (lfpd_pkg::SPEED_W+1)'(wheel_left);
   assign right_ext = (lfpd_pkg::SPEED_W+1)'(wheel_right);

   `LFPD_ASSERT_NEXT(busy_after_accept, req_tvalid && req_tready, !req_tready)
   `LFPD_ASSERT_SAME(left_within_limit, rsp_tvalid, left_ext <= limit_pos && left_ext >= limit_neg)
   `LFPD_ASSERT_SAME(right_within_limit, rsp_tvalid, right_ext <= limit_pos && right_ext >= limit_neg)
   `LFPD_ASSERT_SAME(zero_total_centred, rsp_tvalid && sample_total == '0, line_position == '0)

endmodule

`default_nettype wire
